// ===== hdl/rlcg_pkg.sv =====
package rlcg_pkg;

    // Q.10 fixed point for all factors
    localparam int Q_FRAC = 10;
    localparam int Q_ONE  = 1 << Q_FRAC;

    // Coefficient widths, sized for channels of up to 12 bits
    localparam int CQ_W  = 14;  // contrast factor, 0 .. 10.0
    localparam int IT_W  = 12;  // intensity gain, 0 .. 2.0
    localparam int OFF_W = 16;  // mid-grey offset plus lightness, signed

    // Settings register indexes
    typedef enum logic [1:0] {
        CFG_LIGHTNESS = 2'd0,
        CFG_CONTRAST  = 2'd1,
        CFG_INTENSITY = 2'd2
    } t_cfg_reg;

    // Operation carried in tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    // Derived per-pixel coefficients
    typedef struct packed {
        logic [CQ_W-1:0]  cq;   // contrast factor, Q.10
        logic [OFF_W-1:0] off;  // channel offset, two's complement
        logic [IT_W-1:0]  it;   // intensity gain, Q.10
    } t_coef;

    // Stage advance enables of the pixel pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

endpackage

// ===== hdl/rlcg_gamma_ram.sv =====
module rlcg_gamma_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/rlcg_coef.sv =====
module rlcg_coef #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    output rlcg_pkg::t_coef  o_coef
);
    import rlcg_pkg::*;

    localparam int MAG_W       = 20;
    localparam int RECIP_SHIFT = 27;
    localparam int RECIP_W     = 21;
    localparam int RECIP       = (2**RECIP_SHIFT + 99) / 100;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam int QUO_W       = 14;
    localparam int CHAN_MID    = 2**(CHANNEL_BITS-1) - 1;
    localparam int DIFF_W      = CQ_W + 2;
    localparam int PM_W        = DIFF_W + CHANNEL_BITS;

    logic signed [7:0]        set_val;
    logic                     set_neg;
    logic                     set_pos;
    logic [6:0]               set_mag;
    logic [MAG_W-1:0]         mag;
    logic [PROD_W-1:0]        quo_prod;
    logic [QUO_W-1:0]         quo;
    logic [OFF_W-1:0]         n_l;
    logic [CQ_W-1:0]          n_cq;
    logic [IT_W-1:0]          n_it;
    logic [OFF_W-1:0]         r_l;
    logic [CQ_W-1:0]          r_cq;
    logic [IT_W-1:0]          r_it;
    logic [OFF_W-1:0]         r_off;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PM_W-1:0]   pm;
    logic [PM_W-1:0]          pm_mag;
    logic [PM_W-1:0]          cc_mag;
    logic [OFF_W-1:0]         cc;
    logic [OFF_W-1:0]         n_off;

    // Saturate the setting to -100 .. 100
    always_comb begin
        set_val = $signed(i_cfg_data);
        if (set_val > 8'sd100) begin
            set_val = 8'sd100;
        end else if (set_val < -8'sd100) begin
            set_val = -8'sd100;
        end
        set_neg = set_val[7];
        set_pos = !set_val[7] && (set_val != 8'sd0);
        set_mag = set_neg ? 7'(-set_val) : 7'(set_val);
    end

    // Scaled magnitude to be divided by 100
    always_comb begin
        unique case (t_cfg_reg'(i_cfg_index))
            CFG_LIGHTNESS: mag = (MAG_W'(set_mag) << CHANNEL_BITS) - MAG_W'(set_mag);
            CFG_CONTRAST: begin
                if (set_pos) begin
                    mag = ((MAG_W'(set_mag) << 3) + MAG_W'(set_mag)) << Q_FRAC;
                end else begin
                    mag = MAG_W'(set_mag) << Q_FRAC;
                end
            end
            CFG_INTENSITY: mag = MAG_W'(set_mag) << Q_FRAC;
            default:       mag = '0;
        endcase
    end

    // Divide by 100 through a reciprocal, exact below 2^20
    assign quo_prod = PROD_W'(mag) * PROD_W'(RECIP);
    assign quo      = quo_prod[RECIP_SHIFT +: QUO_W];

    // Apply the sign, truncation toward zero
    assign n_l  = set_neg ? OFF_W'(-OFF_W'(quo)) : OFF_W'(quo);
    assign n_cq = set_pos ? CQ_W'(Q_ONE) + CQ_W'(quo) : CQ_W'(Q_ONE) - CQ_W'(quo);
    assign n_it = set_pos ? IT_W'(Q_ONE) + IT_W'(quo) : IT_W'(Q_ONE) - IT_W'(quo);

    // Capture settings on a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l  <= '0;
            r_cq <= CQ_W'(Q_ONE);
            r_it <= IT_W'(Q_ONE);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_LIGHTNESS: r_l  <= n_l;
                CFG_CONTRAST:  r_cq <= n_cq;
                CFG_INTENSITY: r_it <= n_it;
                default: begin
                end
            endcase
        end
    end

    // Mid-grey offset: trunc(MID * (1 - c)), then add lightness
    assign diff   = $signed(DIFF_W'(Q_ONE)) - $signed({2'b00, r_cq});
    assign pm     = PM_W'(diff) * $signed(PM_W'(CHAN_MID));
    assign pm_mag = pm[PM_W-1] ? PM_W'(-pm) : PM_W'(pm);
    assign cc_mag = pm_mag >> Q_FRAC;
    assign cc     = pm[PM_W-1] ? OFF_W'(-OFF_W'(cc_mag)) : OFF_W'(cc_mag);
    assign n_off  = cc + r_l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= '0;
        end else begin
            r_off <= n_off;
        end
    end

    assign o_coef = '{cq: r_cq, off: r_off, it: r_it};

endmodule

// ===== hdl/rlcg_chan.sv =====
module rlcg_chan #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                     i_clk,
    input  rlcg_pkg::t_pipe_en       i_en,
    input  rlcg_pkg::t_coef          i_coef,
    input  logic [CHANNEL_BITS-1:0]  i_x,
    output logic [CHANNEL_BITS-1:0]  o_level
);
    import rlcg_pkg::*;

    localparam int MUL_W  = CHANNEL_BITS + CQ_W;
    localparam int SUM_W  = MUL_W + 2;
    localparam int PROD_W = SUM_W + IT_W + 1;
    localparam int SHIFT  = 2 * Q_FRAC;

    logic [CHANNEL_BITS-1:0]  r_x;
    logic [MUL_W-1:0]         r_mul;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  off_q;
    logic signed [PROD_W-1:0] it_s;
    logic                     is_pos;
    logic                     is_over;

    assign off_q = $signed(SUM_W'($signed(i_coef.off))) <<< Q_FRAC;
    assign it_s  = $signed(PROD_W'({1'b0, i_coef.it}));

    // Advance the channel datapath stage by stage
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_x <= i_x;
        end
        if (i_en.s2) begin
            r_mul <= MUL_W'(r_x) * MUL_W'(i_coef.cq);
        end
        if (i_en.s3) begin
            r_sum <= $signed({2'b00, r_mul}) + off_q;
        end
        if (i_en.s4) begin
            r_prod <= PROD_W'(r_sum) * it_s;
        end
    end

    // Clamp the Q.20 product to the channel range
    assign is_pos  = !r_prod[PROD_W-1] && (r_prod != '0);
    assign is_over = r_prod[PROD_W-1:SHIFT+CHANNEL_BITS] != '0;

    always_comb begin
        if (!is_pos) begin
            o_level = '0;
        end else if (is_over) begin
            o_level = '1;
        end else begin
            o_level = r_prod[SHIFT +: CHANNEL_BITS];
        end
    end

endmodule

// ===== hdl/rgb_lightness_contrast_gamma.sv =====
// A pixel is registered at the input, contrast, offset, intensity and gamma lookup stages.
// Throughput: one transaction per cycle while the output is not stalled, pixels and table loads alike; each stage
// moves on when the next one is empty or moving, so bubbles close up under backpressure.
// Table loads write the gamma memories in the last stage, in order with pixel lookups.
// Reset (synchronous, active low) clears the pipeline valids and the settings to zero;
// the gamma table is not cleared and must be loaded before pixels are sent.
module rgb_lightness_contrast_gamma #(
    parameter int CHANNEL_BITS = 8,
    localparam int IN_W  = ((5 * CHANNEL_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // red_in, green_in, blue_in, table_index, table_value, zero pad
    input  logic [IN_W-1:0]  i_s_tdata,
    // operation
    input  logic [0:0]       i_s_tuser,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // red_out, green_out, blue_out, zero pad
    output logic [OUT_W-1:0] o_m_tdata,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data
);
    import rlcg_pkg::*;

    localparam int CB = CHANNEL_BITS;

    t_coef          coef;
    t_pipe_en       en;
    logic           en5;
    logic           r_v1, r_v2, r_v3, r_v4, r_m_valid;
    logic           r_op1, r_op2, r_op3, r_op4;
    logic [CB-1:0]  r_idx1, r_idx2, r_idx3, r_idx4;
    logic [CB-1:0]  r_val1, r_val2, r_val3, r_val4;
    logic [CB-1:0]  level_r, level_g, level_b;
    logic [CB-1:0]  gam_r, gam_g, gam_b;
    logic           tbl_we;

    // Settings and derived coefficients
    rlcg_coef #(.CHANNEL_BITS(CB)) u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (coef)
    );

    // Stage enables: a stage moves when the next is empty or moving
    assign en5   = !r_m_valid || i_m_tready;
    assign en.s4 = !r_v4 || en5;
    assign en.s3 = !r_v3 || en.s4;
    assign en.s2 = !r_v2 || en.s3;
    assign en.s1 = !r_v1 || en.s2;
    assign o_s_tready = en.s1;

    // Advance valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (en.s1) r_v1 <= i_s_tvalid;
            if (en.s2) r_v2 <= r_v1;
            if (en.s3) r_v3 <= r_v2;
            if (en.s4) r_v4 <= r_v3;
            if (en5)   r_m_valid <= r_v4 && (r_op4 == OP_PIXEL);
        end
    end

    // Carry operation and table load fields along the pipeline
    always_ff @(posedge i_clk) begin
        if (en.s1) begin
            r_op1  <= i_s_tuser[0];
            r_idx1 <= i_s_tdata[3*CB +: CB];
            r_val1 <= i_s_tdata[4*CB +: CB];
        end
        if (en.s2) begin
            r_op2  <= r_op1;
            r_idx2 <= r_idx1;
            r_val2 <= r_val1;
        end
        if (en.s3) begin
            r_op3  <= r_op2;
            r_idx3 <= r_idx2;
            r_val3 <= r_val2;
        end
        if (en.s4) begin
            r_op4  <= r_op3;
            r_idx4 <= r_idx3;
            r_val4 <= r_val3;
        end
    end

    // Channel datapaths
    rlcg_chan #(.CHANNEL_BITS(CB)) u_chan_r (
        .i_clk (i_clk), .i_en (en), .i_coef (coef),
        .i_x (i_s_tdata[0 +: CB]), .o_level (level_r)
    );
    rlcg_chan #(.CHANNEL_BITS(CB)) u_chan_g (
        .i_clk (i_clk), .i_en (en), .i_coef (coef),
        .i_x (i_s_tdata[CB +: CB]), .o_level (level_g)
    );
    rlcg_chan #(.CHANNEL_BITS(CB)) u_chan_b (
        .i_clk (i_clk), .i_en (en), .i_coef (coef),
        .i_x (i_s_tdata[2*CB +: CB]), .o_level (level_b)
    );

    // Gamma table, one copy per channel, loaded in the lookup stage
    assign tbl_we = r_v4 && (r_op4 == OP_LOAD) && en5;

    rlcg_gamma_ram #(.AW(CB), .DW(CB)) u_gam_r (
        .i_clk (i_clk), .i_we (tbl_we), .i_waddr (r_idx4), .i_wdata (r_val4),
        .i_re (en5), .i_raddr (level_r), .o_rdata (gam_r)
    );
    rlcg_gamma_ram #(.AW(CB), .DW(CB)) u_gam_g (
        .i_clk (i_clk), .i_we (tbl_we), .i_waddr (r_idx4), .i_wdata (r_val4),
        .i_re (en5), .i_raddr (level_g), .o_rdata (gam_g)
    );
    rlcg_gamma_ram #(.AW(CB), .DW(CB)) u_gam_b (
        .i_clk (i_clk), .i_we (tbl_we), .i_waddr (r_idx4), .i_wdata (r_val4),
        .i_re (en5), .i_raddr (level_b), .o_rdata (gam_b)
    );

    // Output transaction
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_W'({gam_b, gam_g, gam_r});

endmodule
